FILE: hdl/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types, codes and the bitmap orientation function for the LED matrix
// frame buffer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

  localparam int QDepth = 2;

  localparam logic [2:0] REQ_SET    = 3'd0;
  localparam logic [2:0] REQ_GET    = 3'd1;
  localparam logic [2:0] REQ_LOAD   = 3'd2;
  localparam logic [2:0] REQ_ROLL   = 3'd3;
  localparam logic [2:0] REQ_UPLOAD = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  localparam logic [2:0] ORIENT_FLIPPED = 3'd1;
  localparam logic [2:0] ORIENT_RIGHT   = 3'd2;
  localparam logic [2:0] ORIENT_NORMAL  = 3'd3;
  localparam logic [2:0] ORIENT_LEFT    = 3'd4;

  localparam logic [1:0] ROLL_NONE    = 2'd0;
  localparam logic [1:0] ROLL_FORWARD = 2'd1;
  localparam logic [1:0] ROLL_BACK    = 2'd2;

  localparam logic [1:0] PIX_OFF     = 2'd0;
  localparam logic [1:0] PIX_ON      = 2'd1;
  localparam logic [1:0] PIX_INVALID = 2'd2;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef logic [7:0] row_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  row;
    logic [2:0]  bit_idx;
    logic        pix_on;
    logic        pix_ok;
    logic [1:0]  roll_h;
    logic [1:0]  roll_v;
    logic [63:0] rows;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Returns {supported, oriented rows}.
  function automatic logic [64:0] orient_rows(input logic [63:0] bits,
                                              input logic [2:0] dir);
    logic [63:0] dst;
    logic        ok;
    dst = '0;
    ok  = 1'b1;
    case (dir)
      ORIENT_NORMAL: begin
        dst = bits;
      end
      ORIENT_FLIPPED: begin
        for (int j = 0; j < 8; j++) begin
          for (int i = 0; i < 8; i++) begin
            dst[8*j + 7 - i] = bits[8*(7 - j) + i];
          end
        end
      end
      ORIENT_RIGHT: begin
        for (int i = 0; i < 8; i++) begin
          for (int j = 0; j < 8; j++) begin
            dst[8*(7 - i) + 7 - j] = bits[8*j + 7 - i];
          end
        end
      end
      ORIENT_LEFT: begin
        for (int i = 0; i < 8; i++) begin
          for (int j = 0; j < 8; j++) begin
            dst[8*(7 - i) + 7 - j] = bits[8*(7 - j) + i];
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return {ok, dst};
  endfunction

endpackage

FILE: hdl/lmfb_front.sv
// ----------------------------------------------------------------------------
// lmfb_front
// Accepts request items, drops those with no effect, applies the bitmap
// orientation and queues the resulting commands for the back end.
// ----------------------------------------------------------------------------
module lmfb_front import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_gravity_direction,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_pos_x,
  input  logic [3:0]  in_pos_y,
  input  logic        in_pixel_on,
  input  logic [63:0] in_bitmap_rows,
  input  logic [1:0]  in_roll_horizontal,
  input  logic [1:0]  in_roll_vertical,
  input  logic        pop,
  output head_t       head
);

  logic [2:0] gravity_r;
  cmd_t       q_r [QDepth];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  cmd_t        cmd;
  logic        keep;
  logic        push;
  logic [64:0] orient;

  always_comb begin
    orient      = orient_rows(in_bitmap_rows, gravity_r);
    cmd.op      = in_req_type;
    cmd.row     = 3'd7 - in_pos_y[2:0];
    cmd.bit_idx = 3'd7 - in_pos_x[2:0];
    cmd.pix_on  = in_pixel_on;
    cmd.pix_ok  = !in_pos_x[3] && !in_pos_y[3];
    cmd.roll_h  = in_roll_horizontal;
    cmd.roll_v  = in_roll_vertical;
    cmd.rows    = orient[63:0];
    case (in_req_type)
      REQ_SET:    keep = cmd.pix_ok;
      REQ_GET:    keep = 1'b1;
      REQ_LOAD:   keep = orient[64];
      REQ_ROLL:   keep = 1'b1;
      REQ_UPLOAD: keep = 1'b1;
      REQ_CLEAR:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign in_stall   = (count_r == 2'(QDepth));
  assign push       = in_valid && !in_stall && keep;
  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= ORIENT_NORMAL;
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      count_r   <= 2'd0;
    end else begin
      if (cfg_valid) begin
        gravity_r <= cfg_gravity_direction;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: hdl/lmfb_back.sv
// ----------------------------------------------------------------------------
// lmfb_back
// Holds the 8x8 frame store, carries out queued commands and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module lmfb_back import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  head_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [1:0]  out_pixel_state,
  output logic [15:0] out_frame_word,
  output logic        out_last_frame
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  row_t        store_r [8];
  row_t        store_nxt [8];
  row_t        shifted [8];
  logic        state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        load;
  logic        kind_nxt, last_nxt;
  logic [1:0]  pix_nxt;
  logic [15:0] word_nxt;
  logic        out_free;
  cmd_t        c;

  assign c        = head.cmd;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      case (c.roll_h)
        ROLL_FORWARD: shifted[i] = {store_r[i][6:0], 1'b0};
        ROLL_BACK:    shifted[i] = {1'b0, store_r[i][7:1]};
        default:      shifted[i] = store_r[i];
      endcase
    end
  end

  always_comb begin
    store_nxt     = store_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    load          = 1'b0;
    kind_nxt      = KIND_QUERY;
    pix_nxt       = PIX_OFF;
    word_nxt      = '0;
    last_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_EMIT) begin
      if (out_free) begin
        load     = 1'b1;
        kind_nxt = KIND_FRAME;
        word_nxt = {8'(cnt_r) + 8'd1, store_r[cnt_r]};
        last_nxt = (cnt_r == 3'd7);
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
    end else if (head.valid) begin
      case (c.op)
        REQ_SET: begin
          store_nxt[c.row][c.bit_idx] = c.pix_on;
          pop = 1'b1;
        end
        REQ_GET: begin
          if (out_free) begin
            load    = 1'b1;
            pix_nxt = c.pix_ok ? (store_r[c.row][c.bit_idx] ? PIX_ON : PIX_OFF)
                               : PIX_INVALID;
            pop     = 1'b1;
          end
        end
        REQ_LOAD: begin
          for (int i = 0; i < 8; i++) begin
            store_nxt[i] = c.rows[8*i +: 8];
          end
          pop = 1'b1;
        end
        REQ_ROLL: begin
          case (c.roll_v)
            ROLL_FORWARD: begin
              for (int i = 0; i < 7; i++) begin
                store_nxt[i] = shifted[i + 1];
              end
              store_nxt[7] = '0;
            end
            ROLL_BACK: begin
              for (int i = 1; i < 8; i++) begin
                store_nxt[i] = shifted[i - 1];
              end
              store_nxt[0] = '0;
            end
            default: begin
              store_nxt = shifted;
            end
          endcase
          pop = 1'b1;
        end
        REQ_UPLOAD: begin
          state_nxt = ST_EMIT;
          cnt_nxt   = 3'd0;
          pop       = 1'b1;
        end
        REQ_CLEAR: begin
          for (int i = 0; i < 8; i++) begin
            store_nxt[i] = '0;
          end
          state_nxt = ST_EMIT;
          cnt_nxt   = 3'd0;
          pop       = 1'b1;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      store_r     <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result_kind <= kind_nxt;
      out_pixel_state <= pix_nxt;
      out_frame_word  <= word_nxt;
      out_last_frame  <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/led_matrix_frame_buffer_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer_unit
// 8x8 one-bit LED matrix frame store with pixel, bitmap, roll and driver
// frame requests.
//
//   channel  direction  handshake          contents
//   cfg      in         cfg_valid/ready    gravity_direction
//   in       in         in_valid/stall     one request item
//   out      out        out_valid/stall    query answer or driver frame
//
// A kept request is written into the two-entry command queue; the back end
// executes a set, load or roll and puts a query answer into the output
// register once that register is free.
// Upload and clear enter the emit state, then send eight frames, one per store
// row; the back end takes no other command until the last frame is loaded.
// Reset clears the store, the queue and the output valid flag.
// A stalled output holds the back end at the next query or frame; the queue
// keeps accepting until full.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_unit import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_gravity_direction,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_pos_x,
  input  logic [3:0]  in_pos_y,
  input  logic        in_pixel_on,
  input  logic [63:0] in_bitmap_rows,
  input  logic [1:0]  in_roll_horizontal,
  input  logic [1:0]  in_roll_vertical,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [1:0]  out_pixel_state,
  output logic [15:0] out_frame_word,
  output logic        out_last_frame
);

  head_t head;
  logic  pop;

  assign cfg_ready = 1'b1;

  lmfb_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_gravity_direction (cfg_gravity_direction),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_pixel_on           (in_pixel_on),
    .in_bitmap_rows        (in_bitmap_rows),
    .in_roll_horizontal    (in_roll_horizontal),
    .in_roll_vertical      (in_roll_vertical),
    .pop                   (pop),
    .head                  (head)
  );

  lmfb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_pixel_state (out_pixel_state),
    .out_frame_word  (out_frame_word),
    .out_last_frame  (out_last_frame)
  );

endmodule

FILE: hdl/lmfb_checker.sv
// ----------------------------------------------------------------------------
// lmfb_checker
// Port-level checks on the result channel of the frame buffer.
// ----------------------------------------------------------------------------
module lmfb_checker import lmfb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [1:0]  out_pixel_state,
  input logic [15:0] out_frame_word,
  input logic        out_last_frame
);

  a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_QUERY |->
      out_frame_word == 16'd0 && !out_last_frame && out_pixel_state != 2'd3)
    else $error("query answer carries frame fields");

  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FRAME |->
      out_pixel_state == PIX_OFF && out_frame_word[15:8] >= 8'd1 &&
      out_frame_word[15:8] <= 8'd8 && (out_last_frame == (out_frame_word[15:8] == 8'd8)))
    else $error("malformed driver frame");

  a_frame_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_result_kind == KIND_FRAME && !out_last_frame |=>
      out_valid && out_result_kind == KIND_FRAME &&
      out_frame_word[15:8] == $past(out_frame_word[15:8]) + 8'd1)
    else $error("driver frames not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_word) &&
      $stable(out_result_kind))
    else $error("stalled result changed");

endmodule

bind led_matrix_frame_buffer_unit lmfb_checker u_lmfb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_pixel_state (out_pixel_state),
  .out_frame_word  (out_frame_word),
  .out_last_frame  (out_last_frame)
);
